// ===== src/rhwt_pkg.sv =====
`default_nettype none

package rhwt_pkg;

  localparam int ChanW = 8;
  // The quotient magnitude never exceeds 43, so six bits cover it.
  localparam int QuoW = 6;
  // 43 * 255 = 10965 needs fourteen bits.
  localparam int RemW = 14;
  localparam int NumCells = QuoW;

  localparam logic [ChanW-1:0] BASE_RED   = 8'd0;
  localparam logic [ChanW-1:0] BASE_GREEN = 8'd85;
  localparam logic [ChanW-1:0] BASE_BLUE  = 8'd171;
  localparam logic [ChanW-1:0] HUE_SCALE  = 8'd43;
  localparam logic [ChanW-1:0] MASK_ON    = 8'd255;
  localparam logic [ChanW-1:0] MASK_OFF   = 8'd0;

  typedef enum logic [1:0] {
    REG_VALUE_THRESHOLD = 2'd0,
    REG_HUE_CENTER      = 2'd1,
    REG_HUE_SPAN        = 2'd2
  } cfg_reg_t;

  // One pixel on its way through the divider chain.
  typedef struct packed {
    logic             reject;
    logic             neg;
    logic [ChanW-1:0] base;
    logic [ChanW-1:0] bright;
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  dvs;
    logic [QuoW-1:0]  quo;
  } div_word_t;

endpackage

`default_nettype wire

// ===== src/rhwt_prep.sv =====
`default_nettype none

module rhwt_prep
  import rhwt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [ChanW-1:0] value_threshold,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ChanW-1:0] red,
  input  wire logic [ChanW-1:0] green,
  input  wire logic [ChanW-1:0] blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output div_word_t             out_word
);

  logic [ChanW-1:0] hi;
  logic [ChanW-1:0] lo;
  logic [ChanW-1:0] range_w;
  logic [ChanW-1:0] base;
  logic signed [ChanW:0] diff;
  logic             neg;
  logic [ChanW-1:0] mag;
  div_word_t        word_next;

  always_comb begin
    lo = red;
    if (green < lo) begin
      lo = green;
    end
    if (blue < lo) begin
      lo = blue;
    end
    // Ties for the maximum go to red first, then green.
    if (red >= green && red >= blue) begin
      hi   = red;
      base = BASE_RED;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      hi   = green;
      base = BASE_GREEN;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      hi   = blue;
      base = BASE_BLUE;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    range_w = hi - lo;
    neg     = diff[ChanW];
    mag     = neg ? ChanW'(-diff) : diff[ChanW-1:0];

    word_next.reject = (hi == '0) || (hi < value_threshold) || (range_w == '0);
    word_next.neg    = neg;
    word_next.base   = base;
    word_next.bright = hi;
    word_next.rem    = RemW'(mag) * RemW'(HUE_SCALE);
    word_next.dvs    = RemW'(range_w) << (QuoW - 1);
    word_next.quo    = '0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rhwt_cell.sv =====
`default_nettype none

module rhwt_cell
  import rhwt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_word_t in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_word_t      out_word
);

  div_word_t word_next;

  // One restoring step: the divisor starts aligned to the top quotient bit
  // and moves down one place per cell.
  always_comb begin
    word_next = in_word;
    if (in_word.rem >= in_word.dvs) begin
      word_next.rem = in_word.rem - in_word.dvs;
      word_next.quo = {in_word.quo[QuoW-2:0], 1'b1};
    end else begin
      word_next.quo = {in_word.quo[QuoW-2:0], 1'b0};
    end
    word_next.dvs = in_word.dvs >> 1;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rhwt_out.sv =====
`default_nettype none

module rhwt_out
  import rhwt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [ChanW-1:0] hue_center,
  input  wire logic [ChanW-1:0] hue_span,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire div_word_t        in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ChanW-1:0]      mask,
  output logic [ChanW-1:0]      hue,
  output logic [ChanW-1:0]      brightness
);

  logic [ChanW-1:0]        quo_ext;
  logic [ChanW-1:0]        quo_signed;
  logic [ChanW-1:0]        hue_raw;
  logic signed [ChanW+1:0] win_lo;
  logic [ChanW:0]          win_hi;
  logic                    pass;
  logic [ChanW-1:0]        mask_next;
  logic [ChanW-1:0]        hue_next;

  always_comb begin
    quo_ext    = ChanW'(in_word.quo);
    quo_signed = in_word.neg ? (~quo_ext + 1'b1) : quo_ext;
    hue_raw    = in_word.base + quo_signed;
    // Window bounds are plain integers; a bound past either end does not wrap.
    win_lo     = $signed({2'b00, hue_center}) - $signed({2'b00, hue_span});
    win_hi     = {1'b0, hue_center} + {1'b0, hue_span};
    pass       = ($signed({2'b00, hue_raw}) >= win_lo) && ({1'b0, hue_raw} <= win_hi);
    if (in_word.reject) begin
      hue_next  = '0;
      mask_next = MASK_OFF;
    end else begin
      hue_next  = hue_raw;
      mask_next = pass ? MASK_ON : MASK_OFF;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mask       <= mask_next;
      hue        <= hue_next;
      brightness <= in_word.bright;
    end
  end

`ifndef SYNTHESIS
  a_mask_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mask == MASK_OFF || mask == MASK_ON))
    else $error("mask is neither 0 nor 255");

  a_pass_not_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mask == MASK_ON) |-> (brightness != '0))
    else $error("black pixel passed the window");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== src/rgb_hue_window_threshold_core.sv =====
`default_nettype none

// Hue-window classifier for a stream of 8-bit RGB pixels.
// Slave channel s_*: one pixel per word, red/green/blue in s_tdata.
// Master channel m_*: one result word per pixel, in order: mask (255 when
// the pixel lies in the hue window, passes the brightness test and is not
// grey, max above min), hue and brightness (the largest channel).
// Config channel cfg_*: index 0 value_threshold, 1 hue_center, 2 hue_span;
// index 3 is ignored. cfg_ready is always high. Write only while idle.
// A word passes eight register stages: one finds max, min and the scaled
// channel difference, six divider cells each settle one quotient bit, and
// one adds the sector base and tests the window. The core takes one pixel
// per cycle while m_tready is high. Each stage holds its word when the
// next one is full, so a stall on m_tready backs up stage by stage; empty
// stages keep taking pixels until the chain is full.
// Reset (rst, synchronous) empties every stage and clears the three
// configuration registers to 0.
module rgb_hue_window_threshold_core
  import rhwt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // mask[7:0], hue[15:8], brightness[23:16]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [ChanW-1:0] value_threshold;
  logic [ChanW-1:0] hue_center;
  logic [ChanW-1:0] hue_span;

  logic      chain_valid [NumCells+1];
  logic      chain_ready [NumCells+1];
  div_word_t chain_word  [NumCells+1];

  logic [ChanW-1:0] mask;
  logic [ChanW-1:0] hue;
  logic [ChanW-1:0] brightness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_threshold <= '0;
      hue_center      <= '0;
      hue_span        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_VALUE_THRESHOLD: value_threshold <= cfg_data;
        REG_HUE_CENTER:      hue_center      <= cfg_data;
        REG_HUE_SPAN:        hue_span        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rhwt_prep u_prep (
    .clk             (clk),
    .rst             (rst),
    .value_threshold (value_threshold),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .red             (s_tdata[7:0]),
    .green           (s_tdata[15:8]),
    .blue            (s_tdata[23:16]),
    .out_valid       (chain_valid[0]),
    .out_ready       (chain_ready[0]),
    .out_word        (chain_word[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rhwt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  rhwt_out u_out (
    .clk        (clk),
    .rst        (rst),
    .hue_center (hue_center),
    .hue_span   (hue_span),
    .in_valid   (chain_valid[NumCells]),
    .in_ready   (chain_ready[NumCells]),
    .in_word    (chain_word[NumCells]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .mask       (mask),
    .hue        (hue),
    .brightness (brightness)
  );

  assign m_tdata = {brightness, hue, mask};

endmodule

`default_nettype wire
